// File: rtl/sssd_pkg.sv
// shared types and constants of the sliced sparse stream decoder
package sssd_pkg;

    localparam int WORD_BITS  = 16;
    localparam int FIELD_BITS = 32;
    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRANSPOSED = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_LENGTH = 2'd1;

    // command kinds
    localparam logic KIND_CLEAR = 1'b0;
    localparam logic KIND_ACCUM = 1'b1;

    // position in the matrix stream
    typedef enum logic [2:0] {
        PH_COUNT   = 3'd0,
        PH_PAD     = 3'd1,
        PH_ROWS_LO = 3'd2,
        PH_ROWS_HI = 3'd3,
        PH_COEF_LO = 3'd4,
        PH_COEF_HI = 3'd5,
        PH_DELTA   = 3'd6,
        PH_ROW     = 3'd7
    } phase_t;

    // one outgoing command
    typedef struct packed {
        logic                  kind;
        logic [FIELD_BITS-1:0] dst_index;
        logic [FIELD_BITS-1:0] src_index;
        logic [FIELD_BITS-1:0] clear_count;
    } cmd_t;

endpackage

// File: rtl/sssd_if.sv
// handshake channel interfaces of the sliced sparse stream decoder

// matrix stream words
interface sssd_word_if;
    logic                           valid;
    logic                           ready;
    logic [sssd_pkg::WORD_BITS-1:0] word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

// clear and accumulate commands
interface sssd_cmd_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [sssd_pkg::FIELD_BITS-1:0] dst_index;
    logic [sssd_pkg::FIELD_BITS-1:0] src_index;
    logic [sssd_pkg::FIELD_BITS-1:0] clear_count;

    modport source (output valid, output kind, output dst_index, output src_index,
                    output clear_count, input ready);
    modport sink   (input valid, input kind, input dst_index, input src_index,
                    input clear_count, output ready);
endinterface

// configuration register writes
interface sssd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sssd_pkg::CFG_IDX_BITS-1:0] index;
    logic [sssd_pkg::FIELD_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/sliced_sparse_stream_decoder.sv
// top level of the sliced sparse stream decoder
//
// Decodes the 16-bit word stream of a row-sliced sparse matrix (slice count, pad word,
// then per slice a 32-bit row count and coefficient count sent low half first, then
// column delta / row pairs) into clear and accumulate commands. One word is taken per
// cycle unless stalled: each request updates the decode state and, where it produces a
// command, loads the single output register, which can be drained in the same cycle a
// new word enters. A command is output in the cycle after the word that causes it. Row
// base and column are INDEX_BITS wide and wrap at that width; indices are zero-extended
// to 32 bits. Configuration writes take effect at once and are always accepted.
module sliced_sparse_stream_decoder #(
    parameter int INDEX_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    sssd_word_if.sink   stream,
    sssd_cmd_if.source  cmd,
    sssd_cfg_if.sink    cfg
);
    import sssd_pkg::*;

    localparam int IW = INDEX_BITS;

    // configuration
    logic                  transposed_reg;
    logic [FIELD_BITS-1:0] dst_length_reg;

    // decode state
    phase_t                phase_reg,       phase_next;
    logic [WORD_BITS-1:0]  slices_left_reg, slices_left_next;
    logic [IW-1:0]         row_base_reg,    row_base_next;
    logic [IW-1:0]         column_reg,      column_next;
    logic [FIELD_BITS-1:0] coeffs_left_reg, coeffs_left_next;
    logic [FIELD_BITS-1:0] slice_rows_reg,  slice_rows_next;
    logic [WORD_BITS-1:0]  low_half_reg,    low_half_next;

    // result register
    logic                  res_valid_reg;
    cmd_t                  res_reg;
    logic                  emit;
    cmd_t                  res_next;

    logic                  accept;
    logic [IW-1:0]         row_sum;
    logic [WORD_BITS-1:0]  slices_dec;
    logic [FIELD_BITS-1:0] coeffs_dec;
    logic [FIELD_BITS-1:0] word_pair;

    assign stream.ready = !res_valid_reg || cmd.ready;
    assign accept       = stream.valid && stream.ready;
    assign cfg.ready    = 1'b1;

    assign row_sum    = row_base_reg + IW'(stream.word);
    assign slices_dec = slices_left_reg - WORD_BITS'(1);
    assign coeffs_dec = coeffs_left_reg - FIELD_BITS'(1);
    assign word_pair  = {stream.word, low_half_reg};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transposed_reg <= 1'b0;
            dst_length_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_TRANSPOSED: transposed_reg <= cfg.data[0];
                CFG_DST_LENGTH: dst_length_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // next decode state
    always_comb
    begin
        phase_next       = phase_reg;
        slices_left_next = slices_left_reg;
        row_base_next    = row_base_reg;
        column_next      = column_reg;
        coeffs_left_next = coeffs_left_reg;
        slice_rows_next  = slice_rows_reg;
        low_half_next    = low_half_reg;
        case (phase_reg)
            PH_COUNT:
            begin
                slices_left_next = stream.word;
                row_base_next    = '0;
                column_next      = '0;
                phase_next       = PH_PAD;
            end
            PH_PAD:
            begin
                phase_next = (slices_left_reg != '0) ? PH_ROWS_LO : PH_COUNT;
            end
            PH_ROWS_LO:
            begin
                low_half_next = stream.word;
                phase_next    = PH_ROWS_HI;
            end
            PH_ROWS_HI:
            begin
                slice_rows_next = word_pair;
                phase_next      = PH_COEF_LO;
            end
            PH_COEF_LO:
            begin
                low_half_next = stream.word;
                phase_next    = PH_COEF_HI;
            end
            PH_COEF_HI:
            begin
                coeffs_left_next = word_pair;
                column_next      = '0;
                if (word_pair == '0)
                begin
                    // empty slice ends at once
                    row_base_next    = row_base_reg + slice_rows_reg[IW-1:0];
                    slices_left_next = slices_dec;
                    phase_next       = (slices_dec != '0) ? PH_ROWS_LO : PH_COUNT;
                end
                else
                begin
                    phase_next = PH_DELTA;
                end
            end
            PH_DELTA:
            begin
                column_next = column_reg + IW'(stream.word);
                phase_next  = PH_ROW;
            end
            PH_ROW:
            begin
                coeffs_left_next = coeffs_dec;
                if (coeffs_dec == '0)
                begin
                    row_base_next    = row_base_reg + slice_rows_reg[IW-1:0];
                    slices_left_next = slices_dec;
                    phase_next       = (slices_dec != '0) ? PH_ROWS_LO : PH_COUNT;
                end
                else
                begin
                    phase_next = PH_DELTA;
                end
            end
            default:
            begin
                phase_next = PH_COUNT;
            end
        endcase
    end

    // command produced by the current word
    always_comb
    begin
        emit     = 1'b0;
        res_next = '0;
        case (phase_reg)
            PH_COUNT:
            begin
                if (transposed_reg)
                begin
                    emit                 = 1'b1;
                    res_next.kind        = KIND_CLEAR;
                    res_next.clear_count = dst_length_reg;
                end
            end
            PH_ROWS_HI:
            begin
                if (!transposed_reg)
                begin
                    emit                 = 1'b1;
                    res_next.kind        = KIND_CLEAR;
                    res_next.dst_index   = FIELD_BITS'(row_base_reg);
                    res_next.clear_count = word_pair;
                end
            end
            PH_ROW:
            begin
                emit          = 1'b1;
                res_next.kind = KIND_ACCUM;
                if (transposed_reg)
                begin
                    res_next.dst_index = FIELD_BITS'(column_reg);
                    res_next.src_index = FIELD_BITS'(row_sum);
                end
                else
                begin
                    res_next.dst_index = FIELD_BITS'(row_sum);
                    res_next.src_index = FIELD_BITS'(column_reg);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // decode state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_COUNT;
            slices_left_reg <= '0;
            row_base_reg    <= '0;
            column_reg      <= '0;
            coeffs_left_reg <= '0;
            slice_rows_reg  <= '0;
            low_half_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            slices_left_reg <= slices_left_next;
            row_base_reg    <= row_base_next;
            column_reg      <= column_next;
            coeffs_left_reg <= coeffs_left_next;
            slice_rows_reg  <= slice_rows_next;
            low_half_reg    <= low_half_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= emit;
        end
        else if (cmd.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign cmd.valid       = res_valid_reg;
    assign cmd.kind        = res_reg.kind;
    assign cmd.dst_index   = res_reg.dst_index;
    assign cmd.src_index   = res_reg.src_index;
    assign cmd.clear_count = res_reg.clear_count;

endmodule
